/* sv/stg_pkg.sv */
// Shared constants, types and the quarter-wave sine table for the sine tone generator.
package stg_pkg;

   // Phase accumulator and table geometry.
   localparam int PHASE_BITS = 32;
   localparam int TABLE_BITS = 10;
   localparam int QTBL_N     = 1 << TABLE_BITS;
   localparam int ADDR_BITS  = TABLE_BITS + 1;

   // Field and register widths.
   localparam int STEP_BITS   = 32;
   localparam int AMP_BITS    = 15;
   localparam int SAMPLE_BITS = 16;
   localparam int MAG_BITS    = 15;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 1;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = QPTR_BITS + 1;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PHASE_STEP     = 1'b0,
      REG_TONE_AMPLITUDE = 1'b1
   } csr_index_type;

   // One sample request as it travels from front to back.
   typedef struct packed {
      logic [1:0]            quad;
      logic [TABLE_BITS-1:0] k;
   } stg_item_type;

   // Quarter-wave table: round(32767 * sin(pi/2 * i / N)) for i = 0..N.
   typedef logic [MAG_BITS-1:0] qtbl_type [0:QTBL_N];

   localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

   // Series divisors (2n)(2n+1) held as reciprocals ceil(2^74 / d). Since every
   // divisor is below 2^10, the product with a 64-bit dividend shifted right by 74
   // gives the exact integer quotient.
   localparam int                 RECIP_SHIFT = 74;
   localparam logic [RECIP_SHIFT:0] RECIP_ONE = 75'd1 << RECIP_SHIFT;
   localparam logic [RECIP_SHIFT:0] SERIES_RECIP [1:14] = '{
      (RECIP_ONE + 75'd5)   / 75'd6,
      (RECIP_ONE + 75'd19)  / 75'd20,
      (RECIP_ONE + 75'd41)  / 75'd42,
      (RECIP_ONE + 75'd71)  / 75'd72,
      (RECIP_ONE + 75'd109) / 75'd110,
      (RECIP_ONE + 75'd155) / 75'd156,
      (RECIP_ONE + 75'd209) / 75'd210,
      (RECIP_ONE + 75'd271) / 75'd272,
      (RECIP_ONE + 75'd341) / 75'd342,
      (RECIP_ONE + 75'd419) / 75'd420,
      (RECIP_ONE + 75'd505) / 75'd506,
      (RECIP_ONE + 75'd599) / 75'd600,
      (RECIP_ONE + 75'd701) / 75'd702,
      (RECIP_ONE + 75'd811) / 75'd812
   };

   // (a * b) >> 62, kept to 64 bits.
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] full;
      full = {64'd0, a} * {64'd0, b};
      return full[125:62];
   endfunction

   // Taylor series for sin(x), x in Q62 and at most pi/2.
   function automatic logic [63:0] sin_q62(input logic [63:0] x);
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [138:0] scaled;
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int n = 1; n <= 14; n++) begin
         scaled = {75'd0, mul_q62(term, x2)} * {64'd0, SERIES_RECIP[n]};
         term   = scaled[RECIP_SHIFT+63 -: 64];
         if ((n % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   // Builds the table at elaboration time in 64-bit fixed point.
   function automatic qtbl_type build_qtbl();
      qtbl_type    tbl;
      logic [63:0] x;
      logic [63:0] s;
      logic [63:0] v;
      logic [63:0] idx;
      for (int i = 0; i <= QTBL_N; i++) begin
         idx = 64'(i);
         x = (HALF_PI_Q62 >> TABLE_BITS) * idx
           + (((HALF_PI_Q62 & 64'(QTBL_N - 1)) * idx) >> TABLE_BITS);
         s = sin_q62(x);
         v = ((s >> 20) * 64'd32767 + (64'd1 << 41)) >> 42;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         tbl[i] = v[MAG_BITS-1:0];
      end
      return tbl;
   endfunction

   localparam qtbl_type QUARTER_TBL = build_qtbl();

endpackage

/* sv/stg_front.sv */
// Front part: accepts tick beats, handles restart and advances the phase accumulator.
module stg_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_restart,
   input  logic [stg_pkg::STEP_BITS-1:0] phase_step,
   output logic                          push,
   output stg_pkg::stg_item_type         push_item,
   input  logic                          queue_full
);
   import stg_pkg::*;

   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_in;
   logic [PHASE_BITS-1:0] phase_now;
   logic                  accept;

   // A beat is taken whenever the queue has room.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept;

   // Restart clears the phase before this sample is looked up.
   assign phase_now = req_restart ? '0 : phase_ff;
   assign phase_in  = phase_now + PHASE_BITS'(phase_step);

   // Quadrant and table offset come from the top phase bits.
   assign push_item.quad = phase_now[PHASE_BITS-1 -: 2];
   assign push_item.k    = phase_now[PHASE_BITS-3 -: TABLE_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

endmodule

/* sv/stg_queue.sv */
// Short FIFO that decouples the phase front from the sample back.
module stg_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  stg_pkg::stg_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output stg_pkg::stg_item_type pop_item,
   output logic                  empty
);
   import stg_pkg::*;

   stg_item_type         entry_ff [0:QUEUE_DEPTH-1];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff;
   logic [QCNT_BITS-1:0] count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full     = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* sv/stg_back.sv */
// Back part: table lookup, amplitude scaling and sign, then the output register.
module stg_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            queue_empty,
   input  stg_pkg::stg_item_type           pop_item,
   output logic                            pop,
   input  logic [stg_pkg::AMP_BITS-1:0]    tone_amplitude,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [stg_pkg::SAMPLE_BITS-1:0] rsp_left_sample,
   output logic [stg_pkg::SAMPLE_BITS-1:0] rsp_right_sample
);
   import stg_pkg::*;

   logic                            pipe_en;
   logic [ADDR_BITS-1:0]            addr;
   logic                            s1_valid_ff;
   logic [MAG_BITS-1:0]             s1_mag_ff;
   logic                            s1_neg_ff;
   logic                            s2_valid_ff;
   logic [MAG_BITS-1:0]             s2_prod_ff;
   logic                            s2_neg_ff;
   logic [MAG_BITS+AMP_BITS-1:0]    prod_full;
   logic [SAMPLE_BITS-1:0]          sample_in;
   logic                            rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]          sample_ff;

   // The whole pipeline moves unless a finished beat is held at the output.
   assign pipe_en = !rsp_valid_ff || !rsp_stall;
   assign pop     = pipe_en && !queue_empty;

   // Odd quadrants read the table mirrored.
   assign addr = pop_item.quad[0] ? (ADDR_BITS'(QTBL_N) - ADDR_BITS'(pop_item.k))
                                  : ADDR_BITS'(pop_item.k);

   // Scale by the Q0.15 amplitude, truncating toward zero.
   assign prod_full = s1_mag_ff * tone_amplitude;

   // The lower half of the turn is positive, the upper half negated.
   assign sample_in = s2_neg_ff ? (SAMPLE_BITS'(0) - SAMPLE_BITS'(s2_prod_ff))
                                : SAMPLE_BITS'(s2_prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff  <= pop;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // Datapath registers: table read, product, output sample.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_mag_ff  <= QUARTER_TBL[addr];
         s1_neg_ff  <= pop_item.quad[1];
         s2_prod_ff <= prod_full[MAG_BITS+AMP_BITS-1 -: MAG_BITS];
         s2_neg_ff  <= s1_neg_ff;
         sample_ff  <= sample_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_sample  = sample_ff;
   assign rsp_right_sample = sample_ff;

endmodule

/* sv/sine_tone_generator.sv */
// Top level of the sine tone generator: configuration registers and the front, queue and back.
//
// Direct digital synthesis sine source. Each request beat is one sample tick and yields one
// stereo beat with the same signed 16-bit sample on left and right. A set restart bit clears
// the phase before that sample. The sample is the quarter-wave table value for the top phase
// bits times tone_amplitude (Q0.15), truncated toward zero; the phase then advances by
// phase_step and wraps. A new tick is taken every clock cycle while the result side keeps
// up; the edge that takes a tick writes the queue, and its result then passes the registered
// table read, the multiplier register and the output register. Write phase_step and
// tone_amplitude only while no tick is in flight.
module sine_tone_generator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_restart,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [stg_pkg::SAMPLE_BITS-1:0] rsp_left_sample,
   output logic signed [stg_pkg::SAMPLE_BITS-1:0] rsp_right_sample,
   input  logic                               csr_write_enable,
   input  logic [stg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [stg_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import stg_pkg::*;

   logic [STEP_BITS-1:0]   phase_step_ff;
   logic [AMP_BITS-1:0]    tone_amplitude_ff;
   logic                   push;
   stg_item_type           push_item;
   logic                   queue_full;
   logic                   pop;
   stg_item_type           pop_item;
   logic                   queue_empty;
   logic [SAMPLE_BITS-1:0] left_sample;
   logic [SAMPLE_BITS-1:0] right_sample;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff     <= '0;
         tone_amplitude_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            REG_PHASE_STEP: begin
               phase_step_ff <= csr_write_data[STEP_BITS-1:0];
            end
            REG_TONE_AMPLITUDE: begin
               tone_amplitude_ff <= csr_write_data[AMP_BITS-1:0];
            end
            default: begin
               phase_step_ff <= phase_step_ff;
            end
         endcase
      end
   end

   stg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_restart (req_restart),
      .phase_step  (phase_step_ff),
      .push        (push),
      .push_item   (push_item),
      .queue_full  (queue_full)
   );

   stg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (queue_empty)
   );

   stg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .pop_item         (pop_item),
      .pop              (pop),
      .tone_amplitude   (tone_amplitude_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left_sample  (left_sample),
      .rsp_right_sample (right_sample)
   );

   assign rsp_left_sample  = signed'(left_sample);
   assign rsp_right_sample = signed'(right_sample);

endmodule

/* test/tb_top.sv */
// Testbench for the sine tone generator: stimulus, sample prediction and output checking.
`timescale 1ns / 1ps

module tb_top;
   import stg_pkg::*;

   localparam logic [63:0] QUARTER_TURN_Q62 = 64'h6487ED5110B4611A;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic                          req_restart;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [SAMPLE_BITS-1:0] rsp_left_sample;
   logic signed [SAMPLE_BITS-1:0] rsp_right_sample;
   logic                          csr_write_enable;
   csr_index_type                 csr_index;
   logic [CSR_DATA_BITS-1:0]      csr_write_data;

   // Predictor state: its own copy of the phase and of both registers.
   logic [MAG_BITS-1:0]           quarter_wave [0:QTBL_N];
   logic [PHASE_BITS-1:0]         tone_phase;
   logic [STEP_BITS-1:0]          step_copy;
   logic [AMP_BITS-1:0]           level_copy;

   // Ticks waiting to be sent and samples waiting to come back.
   logic                          tick_queue [$];
   logic signed [SAMPLE_BITS-1:0] expected_frames [$];
   logic signed [SAMPLE_BITS-1:0] want_sample;

   logic                          req_taken;
   int                            idle_pct;
   int                            stall_pct;
   int                            error_count;
   int                            ticks_sent;
   int                            restarts_sent;
   int                            settings_used;

   sine_tone_generator DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left_sample  (rsp_left_sample),
      .rsp_right_sample (rsp_right_sample),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The run must end well within this time even with heavy idling.
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Fixed-point product (a * b) >> 62.
   function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] wide;
      wide = {64'd0, a} * {64'd0, b};
      return wide[125:62];
   endfunction

   // Taylor series of sin(x) for x in Q62 between zero and a quarter turn.
   function automatic logic [63:0] series_sine(input logic [63:0] x);
      logic [63:0] x_sq;
      logic [63:0] term;
      logic [63:0] total;
      x_sq  = q62_product(x, x);
      term  = x;
      total = x;
      for (int n = 1; n <= 14; n++) begin
         term = q62_product(term, x_sq) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            total = total - term;
         end else begin
            total = total + term;
         end
      end
      return total;
   endfunction

   // Quarter-wave table, rounded to 32767 full scale.
   task automatic fill_quarter_wave();
      logic [63:0] angle;
      logic [63:0] level;
      for (int i = 0; i <= QTBL_N; i++) begin
         angle = (QUARTER_TURN_Q62 >> TABLE_BITS) * 64'(i)
               + (((QUARTER_TURN_Q62 & 64'(QTBL_N - 1)) * 64'(i)) >> TABLE_BITS);
         level = ((series_sine(angle) >> 20) * 64'd32767 + (64'd1 << 41)) >> 42;
         if (level > 64'd32767) begin
            level = 64'd32767;
         end
         quarter_wave[i] = level[MAG_BITS-1:0];
      end
   endtask

   // Sample for a phase: folded table lookup, scaled by the level and truncated toward zero.
   function automatic logic signed [SAMPLE_BITS-1:0] tone_sample(input logic [PHASE_BITS-1:0] ph);
      logic [TABLE_BITS+1:0]        top;
      logic [1:0]                   quadrant;
      logic [TABLE_BITS-1:0]        offset;
      logic [MAG_BITS-1:0]          mag;
      logic [MAG_BITS+AMP_BITS-1:0] scaled;
      logic [SAMPLE_BITS-1:0]       magnitude;
      top       = ph[PHASE_BITS-1 -: TABLE_BITS+2];
      quadrant  = top[TABLE_BITS+1:TABLE_BITS];
      offset    = top[TABLE_BITS-1:0];
      mag       = quadrant[0] ? quarter_wave[QTBL_N - int'(offset)] : quarter_wave[offset];
      scaled    = mag * level_copy;
      magnitude = {1'b0, scaled[MAG_BITS+AMP_BITS-1:15]};
      return quadrant[1] ? -magnitude : magnitude;
   endfunction

   // Tick driver: a beat is held until taken, then the next one is offered or a gap is left.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (tick_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            req_restart <= tick_queue.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure.
   always @(negedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
   end

   // Monitor: checks sample beats, predicts from tick beats and tracks register writes.
   always @(posedge clock) begin
      if (reset) begin
         tone_phase = '0;
         step_copy  = '0;
         level_copy = '0;
         req_taken  = 1'b0;
         expected_frames.delete();
      end else begin
         // Compare each sample beat with the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: sample beat with none expected, left %0d right %0d",
                        $time, rsp_left_sample, rsp_right_sample);
               error_count++;
            end else begin
               want_sample = expected_frames.pop_front();
               if (rsp_left_sample !== want_sample) begin
                  $display("%0t: left sample expected %0d, got %0d",
                           $time, want_sample, rsp_left_sample);
                  error_count++;
               end
               if (rsp_right_sample !== want_sample) begin
                  $display("%0t: right sample expected %0d, got %0d",
                           $time, want_sample, rsp_right_sample);
                  error_count++;
               end
            end
         end

         // A tick beat: restart clears the phase, then sample, then advance.
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            if (req_restart) begin
               tone_phase = '0;
               restarts_sent++;
            end
            expected_frames.push_back(tone_sample(tone_phase));
            tone_phase = tone_phase + step_copy;
            ticks_sent++;
         end

         // Register writes; the level keeps only its low bits.
         if (csr_write_enable) begin
            case (csr_index)
               REG_PHASE_STEP: begin
                  step_copy = csr_write_data[STEP_BITS-1:0];
               end
               REG_TONE_AMPLITUDE: begin
                  level_copy = csr_write_data[AMP_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Waits until every tick is sent and every sample is back, then lets the pipe settle.
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (tick_queue.size() != 0 || req_valid || expected_frames.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // Writes both registers while the block is idle.
   task automatic set_tone(input logic [CSR_DATA_BITS-1:0] step,
                           input logic [CSR_DATA_BITS-1:0] level);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= REG_PHASE_STEP;
      csr_write_data   <= step;
      @(negedge clock);
      csr_index        <= REG_TONE_AMPLITUDE;
      csr_write_data   <= level;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // Random ticks: mostly continuing runs, with an occasional restart.
   task automatic queue_ticks(input int count);
      tick_queue.push_back(1'b1);
      for (int i = 1; i < count; i++) begin
         tick_queue.push_back($urandom_range(0, 19) == 0);
      end
   endtask

   initial begin
      logic [CSR_DATA_BITS-1:0] step;
      logic [CSR_DATA_BITS-1:0] level;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_restart      = 1'b0;
      rsp_stall        = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = REG_PHASE_STEP;
      csr_write_data   = '0;
      idle_pct         = 0;
      stall_pct        = 0;
      error_count      = 0;
      ticks_sent       = 0;
      restarts_sent    = 0;
      settings_used    = 0;
      fill_quarter_wave();

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Directed: a sixteenth of a turn per tick at full scale walks every quadrant,
      // including the quarter-turn points that read the last table entry.
      set_tone(32'h1000_0000, 32'hFFFF_FFFF);
      tick_queue.push_back(1'b1);
      repeat (17) tick_queue.push_back(1'b0);
      tick_queue.push_back(1'b1);
      repeat (2) tick_queue.push_back(1'b0);
      wait_drained();

      // Random phases over steps, levels and idle mixes.
      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 6)
            0: step = $urandom_range(1, 32'h0400_0000);
            1: step = 32'h8000_0000;
            2: step = 32'hFFFF_FFFF;
            3: step = '0;
            4: step = $urandom();
            default: step = $urandom_range(1, 32'h0010_0000);
         endcase
         case ((ph / 3) % 4)
            0: level = 32'hFFFF_FFFF;
            1: level = $urandom();
            2: level = $urandom() & ~32'h7FFF;
            default: level = $urandom_range(1, 3);
         endcase
         set_tone(step, level);
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 52; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 52; end
            default: begin idle_pct = 24; stall_pct = 24; end
         endcase
         // The sender pauses halfway until all samples are back.
         queue_ticks(70);
         wait_drained();
         queue_ticks(70);
         wait_drained();
      end

      $display("Sent %0d sample ticks (%0d with restart) across %0d register settings,",
               ticks_sent, restarts_sent, settings_used);
      $display("with sender gaps and result back-pressure each on, off and combined.");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/stg_pkg.sv
sv/stg_front.sv
sv/stg_queue.sv
sv/stg_back.sv
sv/sine_tone_generator.sv
test/tb_top.sv
